// ----- rtl/lrn_pkg.sv -----
package lrn_pkg;

    // width of the magnitude and exponent fields on the ports
    localparam int MAG_BITS  = 64;
    localparam int EXP_BITS  = 64;
    localparam int PREC_BITS = 7;
    localparam int CNT_BITS  = 6;

    // significant width of the magnitude word (8..64)
    localparam int WORD_BITS = 64;

    localparam logic [MAG_BITS-1:0] MAG_MASK = MAG_BITS'({WORD_BITS{1'b1}});
    localparam logic [EXP_BITS-1:0] EXP_MAX  = {1'b0, {(EXP_BITS-1){1'b1}}};

    // packed stream widths, padded to whole bytes
    localparam int IN_FIELD_BITS  = MAG_BITS + EXP_BITS + 1 + PREC_BITS + 2;
    localparam int OUT_FIELD_BITS = MAG_BITS + 1 + EXP_BITS + 1 + 1 + CNT_BITS + 1;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        RND_ZERO  = 2'd0,
        RND_AWAY  = 2'd1,
        RND_FLOOR = 2'd2,
        RND_CEIL  = 2'd3
    } round_mode_t;

    // index of the lowest set bit, zero for an all-zero word
    function automatic logic [CNT_BITS-1:0] low_one(input logic [MAG_BITS-1:0] v);
        logic [CNT_BITS-1:0] n;
        n = '0;
        for (int i = MAG_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                n = CNT_BITS'(i);
            end
        end
        return n;
    endfunction

    // index of the highest set bit, zero for an all-zero word
    function automatic logic [CNT_BITS-1:0] high_one(input logic [MAG_BITS-1:0] v);
        logic [CNT_BITS-1:0] n;
        n = '0;
        for (int i = 0; i < MAG_BITS; i++) begin
            if (v[i]) begin
                n = CNT_BITS'(i);
            end
        end
        return n;
    endfunction

endpackage

// ----- rtl/limb_round_normalize_unit.sv -----
// limb_round_normalize_unit: normalizes and rounds one binary floating-point
// value per beat. A 64-bit magnitude, its sign, a signed base-two exponent, a
// target precision and a directed rounding mode come in; an odd mantissa, the
// sign, the adjusted exponent and rounding status go out. Trailing zeros move
// into the exponent; when more significant bits remain than the precision
// allows, the low bits are dropped, one is added when the mode rounds away from
// zero, and trailing zeros are stripped again. A zero magnitude gives an exact
// zero. The exponent saturates to the largest positive value when the shift
// pushes it past the signed range. Timing: one input register and one result
// register hold each beat, with the whole normalize and round path between
// them, and a new beat is taken every cycle while the result side is not
// stalled; the rate is set by that single combinational path. The block keeps
// no state from one beat to the next.
module limb_round_normalize_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // magnitude[63:0], exponent_in[127:64], is_negative[128],
    // precision[135:129], round_mode[137:136], zero pad[143:138]
    input  logic [lrn_pkg::IN_DATA_BITS-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // mantissa_out[63:0], sign_out[64], exponent_out[128:65], is_zero[129],
    // exact[130], error_shift[136:131], exponent_overflow[137], zero pad[143:138]
    output logic [lrn_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

    localparam int MB = lrn_pkg::MAG_BITS;
    localparam int EB = lrn_pkg::EXP_BITS;
    localparam int PB = lrn_pkg::PREC_BITS;
    localparam int CB = lrn_pkg::CNT_BITS;

    // input field offsets
    localparam int I_EXP  = MB;
    localparam int I_NEG  = I_EXP + EB;
    localparam int I_PREC = I_NEG + 1;
    localparam int I_MODE = I_PREC + PB;

    // input stage
    logic                    in_valid_reg, in_valid_next;
    logic [MB-1:0]           in_mag_reg;
    logic [EB-1:0]           in_exp_reg;
    logic                    in_neg_reg;
    logic [PB-1:0]           in_prec_reg;
    lrn_pkg::round_mode_t    in_mode_reg;

    // result stage
    logic                    out_valid_reg, out_valid_next;
    logic [MB-1:0]           out_mant_reg, out_mant_next;
    logic                    out_sign_reg, out_sign_next;
    logic [EB-1:0]           out_exp_reg, out_exp_next;
    logic                    out_zero_reg, out_zero_next;
    logic                    out_exact_reg, out_exact_next;
    logic [CB-1:0]           out_err_reg, out_err_next;
    logic                    out_ovf_reg, out_ovf_next;

    logic                    in_take;
    logic                    out_open;
    logic                    out_load;

    // datapath
    logic [MB-1:0]           mag;
    logic                    mag_zero;
    logic [CB-1:0]           tz_first;
    logic [PB-1:0]           bits_total;
    logic [PB-1:0]           prec_eff;
    logic [PB-1:0]           bits_sig;
    logic                    need_round;
    logic [PB-1:0]           drop;
    logic [MB-1:0]           kept;
    logic                    away;
    logic [MB-1:0]           bumped;
    logic [CB-1:0]           tz_second;
    logic [PB-1:0]           shift_total;
    logic [EB-1:0]           exp_sum;
    logic                    exp_ovf;

    // handshake: result register frees up when empty or drained this cycle
    assign out_open = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_open;
    assign in_take  = s_tvalid && s_tready;
    assign out_load = in_valid_reg && out_open;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_mag_reg  <= s_tdata[MB-1:0];
            in_exp_reg  <= s_tdata[I_EXP +: EB];
            in_neg_reg  <= s_tdata[I_NEG];
            in_prec_reg <= s_tdata[I_PREC +: PB];
            in_mode_reg <= lrn_pkg::round_mode_t'(s_tdata[I_MODE +: 2]);
        end
    end

    // first normalization: strip trailing zeros, count significant bits
    assign mag        = in_mag_reg & lrn_pkg::MAG_MASK;
    assign mag_zero   = (mag == '0);
    assign tz_first   = lrn_pkg::low_one(mag);
    assign bits_total = PB'(lrn_pkg::high_one(mag)) + PB'(1);
    assign prec_eff   = (in_prec_reg == '0) ? PB'(1) : in_prec_reg;
    assign bits_sig   = bits_total - PB'(tz_first);
    assign need_round = bits_sig > prec_eff;

    // dropping directly from the raw word lands on the same kept bits
    assign drop = bits_total - prec_eff;
    assign kept = mag >> drop[CB-1:0];

    always_comb begin
        unique case (in_mode_reg)
            lrn_pkg::RND_ZERO:  away = 1'b0;
            lrn_pkg::RND_AWAY:  away = 1'b1;
            lrn_pkg::RND_FLOOR: away = in_neg_reg;
            lrn_pkg::RND_CEIL:  away = !in_neg_reg;
            default:            away = 1'b0;
        endcase
    end

    // kept is below 2^63, so the increment never carries out
    assign bumped    = kept + MB'(away);
    assign tz_second = lrn_pkg::low_one(bumped);

    assign shift_total = need_round ? (drop + PB'(tz_second)) : PB'(tz_first);
    assign exp_sum     = in_exp_reg + EB'(shift_total);
    // shift is never negative, so only an upward wrap can happen
    assign exp_ovf     = !in_exp_reg[EB-1] && exp_sum[EB-1];

    always_comb begin
        if (mag_zero) begin
            out_mant_next  = '0;
            out_sign_next  = 1'b0;
            out_exp_next   = '0;
            out_zero_next  = 1'b1;
            out_exact_next = 1'b1;
            out_err_next   = '0;
            out_ovf_next   = 1'b0;
        end else begin
            out_mant_next  = need_round ? (bumped >> tz_second) : (mag >> tz_first);
            out_sign_next  = in_neg_reg;
            out_exp_next   = exp_ovf ? lrn_pkg::EXP_MAX : exp_sum;
            out_zero_next  = 1'b0;
            out_exact_next = !need_round;
            out_err_next   = need_round ? tz_second : '0;
            out_ovf_next   = exp_ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_mant_reg  <= out_mant_next;
            out_sign_reg  <= out_sign_next;
            out_exp_reg   <= out_exp_next;
            out_zero_reg  <= out_zero_next;
            out_exact_reg <= out_exact_next;
            out_err_reg   <= out_err_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = lrn_pkg::OUT_DATA_BITS'({out_ovf_reg, out_err_reg, out_exact_reg,
                                               out_zero_reg, out_exp_reg, out_sign_reg,
                                               out_mant_reg});

`ifndef ASSERT_OFF
    // a nonzero result mantissa is always odd
    a_mant_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_zero_reg) |-> out_mant_reg[0])
        else $error("nonzero result mantissa is even");

    // exact results carry no error shift
    a_exact_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_exact_reg) |-> (out_err_reg == '0))
        else $error("exact result with nonzero error shift");

    // overflow always comes with the saturated exponent
    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_ovf_reg) |-> (out_exp_reg == lrn_pkg::EXP_MAX))
        else $error("exponent overflow without saturation");

    // an item in the input register moves to the result stage when it opens
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_open) |=> out_valid_reg)
        else $error("input stage item not forwarded");

    // input and result stages are both empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!out_valid_reg && !in_valid_reg))
        else $error("pipeline not empty after reset");
`endif

endmodule

// ----- tb/limb_round_normalize_unit_tb.sv -----
module limb_round_normalize_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS  = 900;
    localparam int QUIET_BEATS   = 120;     // tail of the run with no idling
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;       // margin for any stray beat after the pipe drains

    // one operand as it travels on the input stream, last field on top
    typedef struct packed {
        lrn_pkg::round_mode_t          mode;
        logic [lrn_pkg::PREC_BITS-1:0] precision;
        logic                          negative;
        logic [lrn_pkg::EXP_BITS-1:0]  exponent;
        logic [lrn_pkg::MAG_BITS-1:0]  magnitude;
    } operand_t;

    // one rounded value as it comes back on the result stream, last field on top
    typedef struct packed {
        logic                          overflow;
        logic [lrn_pkg::CNT_BITS-1:0]  error_shift;
        logic                          exact;
        logic                          is_zero;
        logic [lrn_pkg::EXP_BITS-1:0]  exponent;
        logic                          sign;
        logic [lrn_pkg::MAG_BITS-1:0]  mantissa;
    } rounded_t;

    // keeps the rounded values still owed by the block, oldest first
    class round_scoreboard;
        rounded_t    owed[$];
        int unsigned failures;

        function automatic int trailing_zeros(logic [lrn_pkg::MAG_BITS-1:0] v);
            int n;
            n = 0;
            while (n < lrn_pkg::MAG_BITS - 1 && !v[n]) begin
                n++;
            end
            return n;
        endfunction

        // normalize, round in the requested direction, renormalize
        function automatic rounded_t round_normalize(operand_t op);
            rounded_t                      r;
            logic [lrn_pkg::MAG_BITS-1:0]  m;
            logic [lrn_pkg::EXP_BITS-1:0]  shifted;
            logic [lrn_pkg::EXP_BITS-1:0]  sum;
            logic                          away;
            int                            tz;
            int                            width;
            int                            keep;
            int                            drop;
            r = '0;
            m = op.magnitude & lrn_pkg::MAG_MASK;
            if (m == '0) begin
                r.is_zero = 1'b1;
                r.exact   = 1'b1;
                return r;
            end
            keep = (op.precision == '0) ? 1 : int'(op.precision);
            tz = trailing_zeros(m);
            m = m >> tz;
            shifted = lrn_pkg::EXP_BITS'(tz);
            width = 0;
            while (width < lrn_pkg::MAG_BITS && (m >> width) != '0) begin
                width++;
            end
            r.exact = 1'b1;
            if (width > keep) begin
                drop = width - keep;
                case (op.mode)
                    lrn_pkg::RND_AWAY:  away = 1'b1;
                    lrn_pkg::RND_FLOOR: away = op.negative;
                    lrn_pkg::RND_CEIL:  away = !op.negative;
                    default:            away = 1'b0;
                endcase
                m = (m >> drop) + lrn_pkg::MAG_BITS'(away);
                tz = trailing_zeros(m);
                m = m >> tz;
                shifted = shifted + lrn_pkg::EXP_BITS'(drop) + lrn_pkg::EXP_BITS'(tz);
                r.error_shift = lrn_pkg::CNT_BITS'(tz);
                r.exact = 1'b0;
            end
            sum = op.exponent + shifted;
            // only an upward wrap can happen, the shift is never negative
            if (!op.exponent[lrn_pkg::EXP_BITS-1] && sum[lrn_pkg::EXP_BITS-1]) begin
                sum = lrn_pkg::EXP_MAX;
                r.overflow = 1'b1;
            end
            r.mantissa = m;
            r.sign     = op.negative;
            r.exponent = sum;
            return r;
        endfunction

        function void note_operand(logic [lrn_pkg::IN_DATA_BITS-1:0] beat);
            operand_t op;
            op = beat[lrn_pkg::IN_FIELD_BITS-1:0];
            owed.push_back(round_normalize(op));
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                failures++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            end
        endfunction

        function void check_result(logic [lrn_pkg::OUT_DATA_BITS-1:0] beat);
            rounded_t got;
            rounded_t want;
            got = beat[lrn_pkg::OUT_FIELD_BITS-1:0];
            if (owed.size() == 0) begin
                failures++;
                $display("%0t: result beat with nothing owed, expected none, got %h",
                         $time, beat);
                return;
            end
            want = owed.pop_front();
            compare("mantissa_out",      want.mantissa,    got.mantissa);
            compare("sign_out",          64'(want.sign),   64'(got.sign));
            compare("exponent_out",      want.exponent,    got.exponent);
            compare("is_zero",           64'(want.is_zero), 64'(got.is_zero));
            compare("exact",             64'(want.exact),  64'(got.exact));
            compare("error_shift",       64'(want.error_shift), 64'(got.error_shift));
            compare("exponent_overflow", 64'(want.overflow), 64'(got.overflow));
        endfunction
    endclass

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    // magnitude, exponent_in, is_negative, precision, round_mode, zero pad
    logic [lrn_pkg::IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    // mantissa_out, sign_out, exponent_out, is_zero, exact, error_shift,
    // exponent_overflow, zero pad
    logic [lrn_pkg::OUT_DATA_BITS-1:0] m_tdata;

    round_scoreboard sb = new();
    bit              quiet_tail = 1'b0;   // no idling on either side once set
    int unsigned     cycle_count = 0;
    operand_t        corner_cases[$];

    limb_round_normalize_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever begin
            #4 aclk = ~aclk;
        end
    end

    // watchdog, sized from the slowest legal run many times over
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // handshakes are sampled mid-cycle, where every signal is settled and
    // holds the value it will have at the next rising edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_operand(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
        end
    end

    // result side: ready stretches broken by stall bursts
    initial begin
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    function automatic operand_t make_operand(logic [63:0] magnitude, logic [63:0] exponent,
                                              logic negative, logic [6:0] precision,
                                              lrn_pkg::round_mode_t mode);
        operand_t op;
        op.magnitude = magnitude;
        op.exponent  = exponent;
        op.negative  = negative;
        op.precision = precision;
        op.mode      = mode;
        return op;
    endfunction

    // mixes dense words, sparse words, runs of ones and powers of two, with
    // exponents clustered near both ends of the signed range and around zero
    function automatic operand_t random_operand();
        operand_t    op;
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       op.magnitude = ($urandom_range(0, 3) == 0) ? '0
                                    : 64'd1 << $urandom_range(0, 63);
            1, 2:    op.magnitude = (w >> $urandom_range(0, 63)) << $urandom_range(0, 63);
            3:       op.magnitude = ({64{1'b1}} >> $urandom_range(0, 63))
                                    << $urandom_range(0, 63);
            default: op.magnitude = w;
        endcase
        case ($urandom_range(0, 7))
            0:       op.exponent = lrn_pkg::EXP_MAX - 64'($urandom_range(0, 130));
            1:       op.exponent = {1'b1, 63'd0} + 64'($urandom_range(0, 130));
            2:       op.exponent = 64'($urandom_range(0, 2000)) - 64'd1000;
            default: op.exponent = {$urandom, $urandom};
        endcase
        // mostly the legal 1..64, now and then any code the field can hold
        op.precision = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(1, 64));
        op.negative  = 1'($urandom_range(0, 1));
        op.mode      = lrn_pkg::round_mode_t'($urandom_range(0, 3));
        return op;
    endfunction

    // one beat on the input side, with an optional idle burst ahead of it;
    // returns on the rising edge that accepts the beat
    task automatic send_operand(operand_t op);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tdata  <= lrn_pkg::IN_DATA_BITS'(op);
        s_tvalid <= 1'b1;
        do begin
            @(negedge aclk);
        end while (!s_tready);
        @(posedge aclk);
    endtask

    initial begin
        // zero magnitude, with fields that must not leak into the result
        corner_cases.push_back(make_operand('0, lrn_pkg::EXP_MAX, 1'b1, 7'd5,
                                            lrn_pkg::RND_AWAY));
        // full word kept whole, and cut to a single bit in every direction
        corner_cases.push_back(make_operand({64{1'b1}}, '0, 1'b0, 7'd64, lrn_pkg::RND_ZERO));
        corner_cases.push_back(make_operand({64{1'b1}}, '0, 1'b0, 7'd1, lrn_pkg::RND_ZERO));
        corner_cases.push_back(make_operand({64{1'b1}}, '0, 1'b0, 7'd1, lrn_pkg::RND_AWAY));
        corner_cases.push_back(make_operand({64{1'b1}}, '0, 1'b1, 7'd1, lrn_pkg::RND_FLOOR));
        corner_cases.push_back(make_operand({64{1'b1}}, '0, 1'b0, 7'd1, lrn_pkg::RND_FLOOR));
        corner_cases.push_back(make_operand({64{1'b1}}, '0, 1'b1, 7'd1, lrn_pkg::RND_CEIL));
        corner_cases.push_back(make_operand({64{1'b1}}, '0, 1'b0, 7'd1, lrn_pkg::RND_CEIL));
        // exponent at the top, pushed past it by stripped zeros alone or left in place
        corner_cases.push_back(make_operand({1'b1, 63'd0}, lrn_pkg::EXP_MAX, 1'b0, 7'd3,
                                            lrn_pkg::RND_ZERO));
        corner_cases.push_back(make_operand(64'd1, lrn_pkg::EXP_MAX, 1'b0, 7'd1,
                                            lrn_pkg::RND_AWAY));
        corner_cases.push_back(make_operand(64'd2, lrn_pkg::EXP_MAX, 1'b1, 7'd64,
                                            lrn_pkg::RND_FLOOR));
        // rounding carry from the lowest exponent
        corner_cases.push_back(make_operand(64'h8000_0000_0000_0001, {1'b1, 63'd0}, 1'b0,
                                            7'd1, lrn_pkg::RND_AWAY));
        // precision zero acts as one, precision past the word never rounds
        corner_cases.push_back(make_operand(64'hB, 64'd10, 1'b0, 7'd0, lrn_pkg::RND_AWAY));
        corner_cases.push_back(make_operand({64{1'b1}}, 64'd7, 1'b1, 7'd127,
                                            lrn_pkg::RND_FLOOR));
        corner_cases.push_back(make_operand(64'h0123_4567_89AB_CDEF, {64{1'b1}}, 1'b1,
                                            7'd12, lrn_pkg::RND_CEIL));
        corner_cases.push_back(make_operand(64'h0123_4567_89AB_CDEF, {64{1'b1}}, 1'b0,
                                            7'd12, lrn_pkg::RND_CEIL));
        // carry ripples through, renormalizes and overflows the exponent
        corner_cases.push_back(make_operand(64'hFFFF_FFFF_FFFF_FFFE,
                                            lrn_pkg::EXP_MAX - 64'd40, 1'b0,
                                            7'd8, lrn_pkg::RND_AWAY));
        // negative exponent wrapping through zero is not an overflow
        corner_cases.push_back(make_operand(64'hAAAA_AAAA_AAAA_AAAA, {64{1'b1}}, 1'b0,
                                            7'd63, lrn_pkg::RND_AWAY));
        corner_cases.push_back(make_operand(64'd1, {1'b1, 63'd0}, 1'b1, 7'd64,
                                            lrn_pkg::RND_FLOOR));
        corner_cases.push_back(make_operand(64'h7FFF_FFFF_FFFF_FFFF, 64'd5, 1'b0, 7'd62,
                                            lrn_pkg::RND_AWAY));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_cases[i]) begin
            send_operand(corner_cases[i]);
        end
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if (i >= RANDOM_BEATS - QUIET_BEATS) begin
                quiet_tail = 1'b1;
            end
            send_operand(random_operand());
        end
        s_tvalid <= 1'b0;

        // let the pipe drain, then wait out a margin for any stray beat
        while (sb.owed.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
